FILE: hw/rtl/aop_pkg.sv
`default_nettype none
package aop_pkg;

	localparam int MAX_STEPS_DEF = 4096;
	localparam int SUM_W = 48;
	localparam int DIV_STEPS = SUM_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [31:0] SPOT_RESET = 32'd6553600;
	localparam logic [12:0] STEPS_RESET = 13'd252;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
	localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [3:0] EXP_LIN_IDX = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPOT, REG_STRIKE, REG_DRIFT, REG_VOL,
		REG_STEPS, REG_AVG_START, REG_FLOAT, REG_PUT
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] spot;
		logic [31:0] strike;
		logic signed [23:0] drift;
		logic signed [23:0] vol;
		logic [12:0] steps;
		logic signed [12:0] avg_start;
		logic floating;
		logic put;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_LOG, OP_LIN, OP_EXP, OP_PRICE,
		OP_UPDATE, OP_DIV_INIT, OP_DIV_STEP, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
		logic [3:0] exp_idx;
	} cmd_t;

	typedef struct packed {
		logic path_end;
	} sts_t;

	typedef struct packed {
		logic [31:0] path_payoff;
		logic [SUM_W-1:0] payoff_accum;
		logic [31:0] paths_done;
		logic empty_average;
	} res_t;

	// 2^(2^-(i+1)) in Q1.30.
	function automatic logic [30:0] pow2_tab(input logic [2:0] i);
		logic [30:0] v;
		case (i)
			3'd0: v = 31'd1518500250;
			3'd1: v = 31'd1276901417;
			3'd2: v = 31'd1170923762;
			3'd3: v = 31'd1121280436;
			3'd4: v = 31'd1097253708;
			3'd5: v = 31'd1085434106;
			3'd6: v = 31'd1079572136;
			default: v = 31'd1076653033;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aop_sample_if.sv
`default_nettype none
interface aop_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] normal_sample;

	modport source(output valid, output normal_sample, input ready);
	modport sink(input valid, input normal_sample, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/aop_result_if.sv
`default_nettype none
interface aop_result_if;
	logic valid;
	logic ready;
	logic [31:0] path_payoff;
	logic [47:0] payoff_accum;
	logic [31:0] paths_done;
	logic empty_average;

	modport source(output valid, output path_payoff, output payoff_accum,
		output paths_done, output empty_average, input ready);
	modport sink(input valid, input path_payoff, input payoff_accum,
		input paths_done, input empty_average, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/aop_ctrl.sv
`default_nettype none
module aop_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic out_free,
	input wire aop_pkg::sts_t sts,
	output aop_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOG, S_LIN, S_EXP, S_PRICE, S_UPDATE, S_DIV_INIT, S_DIV, S_FINISH
	} state_t;

	state_t state_q;
	logic [5:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = aop_pkg::OP_NONE;
		cmd.exp_idx = cnt_q[3:0];
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.op = aop_pkg::OP_LOAD;
			S_LOG: cmd.op = aop_pkg::OP_LOG;
			S_LIN: cmd.op = aop_pkg::OP_LIN;
			S_EXP: cmd.op = aop_pkg::OP_EXP;
			S_PRICE: cmd.op = aop_pkg::OP_PRICE;
			S_UPDATE: cmd.op = aop_pkg::OP_UPDATE;
			S_DIV_INIT: cmd.op = aop_pkg::OP_DIV_INIT;
			S_DIV: cmd.op = aop_pkg::OP_DIV_STEP;
			S_FINISH: if (out_free) cmd.op = aop_pkg::OP_FINISH;
			default: cmd.op = aop_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_LOG;
				S_LOG: state_q <= S_LIN;
				S_LIN: begin
					state_q <= S_EXP;
					cnt_q <= '0;
				end
				S_EXP: begin
					if (cnt_q[3:0] == aop_pkg::EXP_LIN_IDX) state_q <= S_PRICE;
					cnt_q <= cnt_q + 6'd1;
				end
				S_PRICE: state_q <= S_UPDATE;
				S_UPDATE: state_q <= sts.path_end ? S_DIV_INIT : S_IDLE;
				S_DIV_INIT: begin
					state_q <= S_DIV;
					cnt_q <= '0;
				end
				S_DIV: begin
					if (cnt_q == 6'(aop_pkg::DIV_STEPS - 1)) state_q <= S_FINISH;
					cnt_q <= cnt_q + 6'd1;
				end
				S_FINISH: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a word was accepted");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < 6'(aop_pkg::DIV_STEPS))
		else $error("divider step count overran");
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && out_free |=> state_q == S_IDLE)
		else $error("finish did not return to idle");

endmodule
`default_nettype wire

FILE: hw/rtl/aop_dpath.sv
`default_nettype none
module aop_dpath #(
	parameter int MAX_STEPS = aop_pkg::MAX_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire aop_pkg::cfg_t cfg,
	input wire logic signed [15:0] sample,
	input wire aop_pkg::cmd_t cmd,
	output aop_pkg::sts_t sts,
	output aop_pkg::res_t res
);

	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int SW = aop_pkg::SUM_W;

	logic signed [28:0] x_q;
	logic signed [30:0] y_q;
	logic [30:0] lin_q;
	logic [31:0] m_q;
	logic [63:0] p_q;
	logic [31:0] price_q;
	logic [SW-1:0] sum_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SW-1:0] total_q;
	logic [31:0] paths_q;
	logic [SW-1:0] quo_q;
	logic [STEP_W:0] rem_q;

	logic signed [39:0] vs_prod;
	logic signed [28:0] x_next;
	logic signed [60:0] xy_prod;
	logic signed [10:0] k;
	logic [19:0] f;
	logic [41:0] lin_prod;
	logic [30:0] factor;
	logic [62:0] m_prod;
	logic signed [12:0] s;
	logic [5:0] sh;
	logic [12:0] n;
	logic [63:0] rnd;
	logic [63:0] shr;
	logic [31:0] new_price;
	logic [STEP_W-1:0] eff_steps;
	logic averaging;
	logic [SW:0] sum_add;
	logic [STEP_W+1:0] trial;
	logic [31:0] avg;
	logic [31:0] lhs;
	logic [31:0] rhs;
	logic [31:0] payoff;
	logic empty;
	logic [SW:0] total_add;

	always_comb begin
		vs_prod = 40'(cfg.vol) * 40'(sample);
		x_next = 29'(vs_prod >>> 12) + 29'(cfg.drift);
		xy_prod = 61'(x_q) * 61'($signed({1'b0, aop_pkg::LOG2E_Q30}));
		k = 11'(y_q >>> 20);
		f = y_q[19:0];
		lin_prod = 42'(y_q[11:0]) * 42'(aop_pkg::LN2_Q30);
		if (cmd.exp_idx == aop_pkg::EXP_LIN_IDX) begin
			factor = lin_q;
		end else if (f[5'd19 - 5'(cmd.exp_idx)]) begin
			factor = aop_pkg::pow2_tab(cmd.exp_idx[2:0]);
		end else begin
			factor = aop_pkg::ONE_Q30;
		end
		m_prod = 63'(m_q) * 63'(factor);
	end

	// Apply 2^k to price*m, rounding half up on right shifts, saturating on left.
	always_comb begin
		s = 13'sd30 - 13'(k);
		sh = s[5:0];
		n = 13'(-s);
		rnd = p_q + (64'd1 << (sh - 6'd1));
		shr = rnd >> sh;
		if (s >= 13'sd64) begin
			new_price = '0;
		end else if (s > 13'sd0) begin
			new_price = (shr[63:32] != '0) ? aop_pkg::U32_MAX : shr[31:0];
		end else if (p_q == '0) begin
			new_price = '0;
		end else if (n >= 13'd32) begin
			new_price = aop_pkg::U32_MAX;
		end else if ((p_q >> (6'd32 - 6'(n))) != '0) begin
			new_price = aop_pkg::U32_MAX;
		end else begin
			new_price = 32'(p_q << n[4:0]);
		end
	end

	always_comb begin
		if (cfg.steps == '0) begin
			eff_steps = STEP_W'(1);
		end else if (32'(cfg.steps) > 32'(MAX_STEPS)) begin
			eff_steps = STEP_W'(MAX_STEPS);
		end else begin
			eff_steps = STEP_W'(cfg.steps);
		end
		sts.path_end = (32'(step_q) + 32'd1) >= 32'(eff_steps);
		averaging = $signed(32'(step_q)) > 32'(cfg.avg_start);
		sum_add = (SW+1)'(sum_q) + (SW+1)'(new_price);
		trial = {1'b0, rem_q[STEP_W-1:0], quo_q[SW-1]} - (STEP_W+2)'(cnt_q);
	end

	always_comb begin
		avg = (quo_q[SW-1:32] != '0) ? aop_pkg::U32_MAX : quo_q[31:0];
		lhs = cfg.floating ? price_q : avg;
		rhs = cfg.floating ? avg : cfg.strike;
		empty = (cnt_q == '0);
		payoff = '0;
		if (!empty) begin
			if (cfg.put) begin
				payoff = (rhs > lhs) ? rhs - lhs : '0;
			end else begin
				payoff = (lhs > rhs) ? lhs - rhs : '0;
			end
		end
		total_add = (SW+1)'(total_q) + (SW+1)'(payoff);
		res.path_payoff = payoff;
		res.payoff_accum = total_add[SW] ? aop_pkg::SUM_MAX : total_add[SW-1:0];
		res.paths_done = (paths_q == aop_pkg::U32_MAX) ? paths_q : paths_q + 32'd1;
		res.empty_average = empty;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			aop_pkg::OP_LOAD: x_q <= x_next;
			aop_pkg::OP_LOG: y_q <= 31'(xy_prod >>> 30);
			aop_pkg::OP_LIN: begin
				lin_q <= aop_pkg::ONE_Q30 + 31'(lin_prod >> 20);
				m_q <= 32'(aop_pkg::ONE_Q30);
			end
			aop_pkg::OP_EXP: m_q <= 32'((m_prod + 63'(aop_pkg::HALF_Q30)) >> 30);
			aop_pkg::OP_PRICE: p_q <= 64'(price_q) * 64'(m_q);
			aop_pkg::OP_DIV_INIT: begin
				quo_q <= sum_q;
				rem_q <= '0;
			end
			aop_pkg::OP_DIV_STEP: begin
				if (!trial[STEP_W+1]) rem_q <= trial[STEP_W:0];
				else rem_q <= {rem_q[STEP_W-1:0], quo_q[SW-1]};
				quo_q <= {quo_q[SW-2:0], ~trial[STEP_W+1]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_q <= aop_pkg::SPOT_RESET;
			sum_q <= '0;
			step_q <= '0;
			cnt_q <= '0;
			total_q <= '0;
			paths_q <= '0;
		end else begin
			case (cmd.op)
				aop_pkg::OP_UPDATE: begin
					price_q <= new_price;
					if (averaging) begin
						cnt_q <= cnt_q + STEP_W'(1);
						sum_q <= sum_add[SW] ? aop_pkg::SUM_MAX : sum_add[SW-1:0];
					end
					if (!sts.path_end) step_q <= step_q + STEP_W'(1);
				end
				aop_pkg::OP_FINISH: begin
					total_q <= res.payoff_accum;
					paths_q <= res.paths_done;
					price_q <= cfg.spot;
					sum_q <= '0;
					step_q <= '0;
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	a_paths_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 paths_q >= $past(paths_q))
		else $error("path count went down");
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 total_q >= $past(total_q))
		else $error("payoff total went down");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(step_q) < 32'(MAX_STEPS))
		else $error("step index passed the step limit");

endmodule
`default_nettype wire

FILE: hw/rtl/asian_option_mc_path.sv
// Asian option path engine for geometric Brownian motion in Q16.16.
// Input channel "samples" carries one standard-normal word (Q3.12) per time step.
// Each word advances the path price by exp(drift + vol * sample); after the
// last step of a path the block forms the average, the payoff and the totals,
// and offers one word on the "results" channel. Other steps give no result.
// Registers are written through cfg_wr_en / cfg_idx / cfg_wdata while idle; the
// user must keep to this, as the block itself does not enforce it.
// A new sample is taken only once the previous step is done. The step runs on
// the exp sequencer: one log2 multiply, the linear term, nine rounding multiplies
// on the mantissa, the price multiply and the 2^k shift, one of each per cycle.
// A path-ending step then runs the 48-step restoring divider that forms the
// average. The result sits in an output register, so the next sample is accepted
// while it waits. If the receiver stalls when a second path ends, the engine holds
// at that path end until the register frees.
// Reset loads the default registers, puts the path at the reset spot price
// and clears the payoff total and the path count.
`default_nettype none
module asian_option_mc_path #(
	parameter int MAX_STEPS = aop_pkg::MAX_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [aop_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [aop_pkg::CFG_DATA_W-1:0] cfg_wdata,
	aop_sample_if.sink samples,
	aop_result_if.source results
);

	aop_pkg::cfg_t cfg_q;
	aop_pkg::cmd_t cmd;
	aop_pkg::sts_t sts;
	aop_pkg::res_t res;
	aop_pkg::res_t out_q;
	logic out_valid_q;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spot <= aop_pkg::SPOT_RESET;
			cfg_q.strike <= aop_pkg::SPOT_RESET;
			cfg_q.drift <= '0;
			cfg_q.vol <= '0;
			cfg_q.steps <= aop_pkg::STEPS_RESET;
			cfg_q.avg_start <= '0;
			cfg_q.floating <= 1'b0;
			cfg_q.put <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (aop_pkg::cfg_reg_t'(cfg_idx))
				aop_pkg::REG_SPOT: cfg_q.spot <= cfg_wdata;
				aop_pkg::REG_STRIKE: cfg_q.strike <= cfg_wdata;
				aop_pkg::REG_DRIFT: cfg_q.drift <= cfg_wdata[23:0];
				aop_pkg::REG_VOL: cfg_q.vol <= cfg_wdata[23:0];
				aop_pkg::REG_STEPS: cfg_q.steps <= cfg_wdata[12:0];
				aop_pkg::REG_AVG_START: cfg_q.avg_start <= cfg_wdata[12:0];
				aop_pkg::REG_FLOAT: cfg_q.floating <= cfg_wdata[0];
				aop_pkg::REG_PUT: cfg_q.put <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || results.ready;

	aop_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.out_free(out_free),
		.sts(sts),
		.cmd(cmd)
	);

	aop_dpath #(
		.MAX_STEPS(MAX_STEPS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.sample(samples.normal_sample),
		.cmd(cmd),
		.sts(sts),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == aop_pkg::OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == aop_pkg::OP_FINISH) out_q <= res;
	end

	assign results.valid = out_valid_q;
	assign results.path_payoff = out_q.path_payoff;
	assign results.payoff_accum = out_q.payoff_accum;
	assign results.paths_done = out_q.paths_done;
	assign results.empty_average = out_q.empty_average;

endmodule
`default_nettype wire

FILE: dv/asian_option_mc_path_tb.sv
`default_nettype none
module asian_option_mc_path_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 2000000;
	localparam longint LOG2E_K = 64'd1549082005;
	localparam longint unsigned LN2_K = 64'd744261118;
	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned Q30_HALF = 64'd536870912;
	localparam longint unsigned TOTAL_MAX = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned WORD_MAX = 64'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [aop_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [aop_pkg::CFG_DATA_W-1:0] cfg_wdata;

	aop_sample_if samp();
	aop_result_if res();

	asian_option_mc_path DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.samples(samp.sink),
		.results(res.source)
	);

	// Mantissa factors 2^(2^-(i+1)) in Q1.30.
	longint unsigned half_pow [8] = '{
		64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
		64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033
	};

	// Shadow copy of the registers and of the path state.
	logic [31:0] sh_spot, sh_strike;
	logic signed [23:0] sh_drift, sh_vol;
	logic [12:0] sh_steps;
	logic signed [12:0] sh_avg_start;
	logic sh_floating, sh_put;
	logic [31:0] path_price;
	longint unsigned path_sum;
	int unsigned step_idx, avg_cnt;
	longint unsigned payoff_acc;
	longint unsigned path_cnt;

	logic signed [15:0] sample_q[$];
	aop_pkg::res_t payoff_q[$];
	int errors;
	longint cycles;
	int send_gap, recv_gap, hold_cnt;
	bit send_idle, recv_idle, hold_start;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [31:0] gbm_step(logic [31:0] price, logic signed [15:0] z);
		longint x, y, k, s;
		logic [19:0] f;
		longint unsigned m, lin, p, r;
		x = longint'(sh_drift) + ((longint'(sh_vol) * longint'(z)) >>> 12);
		y = (x * LOG2E_K) >>> 30;
		k = y >>> 20;
		f = y[19:0];
		m = Q30_ONE;
		for (int i = 0; i < 8; i++)
			if (f[19-i])
				m = (m * half_pow[i] + Q30_HALF) >> 30;
		lin = Q30_ONE + ((longint'(f[11:0]) * LN2_K) >> 20);
		m = (m * lin + Q30_HALF) >> 30;
		p = longint'(price) * m;
		s = 30 - k;
		if (s >= 64)
			return 32'd0;
		if (s > 0) begin
			r = (p + (64'd1 << (s - 1))) >> s;
			return (r > WORD_MAX) ? 32'hFFFF_FFFF : r[31:0];
		end
		if (p == 0)
			return 32'd0;
		if (-s >= 32 || p > (WORD_MAX >> (-s)))
			return 32'hFFFF_FFFF;
		r = p << (-s);
		return r[31:0];
	endfunction

	// Advances the shadow path by one word; returns 1 with the payoff word at path end.
	function automatic bit path_advance(logic signed [15:0] z, output aop_pkg::res_t out);
		int unsigned eff_steps;
		longint unsigned avg, lhs, rhs, tmp, payoff;
		eff_steps = (sh_steps == 0) ? 1 : ((sh_steps > 4096) ? 4096 : sh_steps);
		payoff = 0;
		out = '0;
		path_price = gbm_step(path_price, z);
		if (int'(step_idx) > int'(sh_avg_start)) begin
			avg_cnt = (avg_cnt + 1) & 32'h1FFF;
			path_sum += path_price;
			if (path_sum > TOTAL_MAX)
				path_sum = TOTAL_MAX;
		end
		if (step_idx + 1 < eff_steps) begin
			step_idx = (step_idx + 1) & 32'h1FFF;
			return 1'b0;
		end
		out.empty_average = (avg_cnt == 0);
		if (avg_cnt != 0) begin
			avg = path_sum / avg_cnt;
			if (avg > WORD_MAX)
				avg = WORD_MAX;
			lhs = sh_floating ? longint'(path_price) : avg;
			rhs = sh_floating ? avg : longint'(sh_strike);
			if (sh_put) begin
				tmp = lhs;
				lhs = rhs;
				rhs = tmp;
			end
			payoff = (lhs > rhs) ? lhs - rhs : 0;
		end
		payoff_acc += payoff;
		if (payoff_acc > TOTAL_MAX)
			payoff_acc = TOTAL_MAX;
		if (path_cnt < WORD_MAX)
			path_cnt++;
		out.path_payoff = payoff[31:0];
		out.payoff_accum = payoff_acc[47:0];
		out.paths_done = path_cnt[31:0];
		path_price = sh_spot;
		path_sum = 0;
		step_idx = 0;
		avg_cnt = 0;
		return 1'b1;
	endfunction

	task automatic cfg_write(aop_pkg::cfg_reg_t r, logic [31:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		case (r)
			aop_pkg::REG_SPOT: sh_spot = v;
			aop_pkg::REG_STRIKE: sh_strike = v;
			aop_pkg::REG_DRIFT: sh_drift = v[23:0];
			aop_pkg::REG_VOL: sh_vol = v[23:0];
			aop_pkg::REG_STEPS: sh_steps = v[12:0];
			aop_pkg::REG_AVG_START: sh_avg_start = v[12:0];
			aop_pkg::REG_FLOAT: sh_floating = v[0];
			default: sh_put = v[0];
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Waits until every word is sent and every payoff has come, then lets the
	// engine finish any step that gives no result.
	task automatic settle();
		while (sample_q.size() != 0 || samp.valid || payoff_q.size() != 0 || hold_cnt != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample(bit wide);
		if (wide || $urandom_range(0, 3) == 0)
			return 16'($urandom());
		return 16'($urandom_range(0, 8000) - 4000);
	endfunction

	// Sender.
	always @(posedge clk) begin
		if (!arst_n) begin
			samp.valid <= 1'b0;
			send_gap <= 0;
		end else if (!samp.valid || samp.ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				samp.valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				samp.valid <= 1'b1;
				samp.normal_sample <= sample_q.pop_front();
				send_gap <= send_idle ? $urandom_range(0, 9) : 0;
			end else begin
				samp.valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted in its own process.
	always @(posedge clk) begin
		if (hold_start)
			hold_cnt <= 2500;
		else if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
	end

	// Receiver.
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_start || hold_cnt > 1) begin
			res.ready <= 1'b0;
		end else if (res.valid && res.ready) begin
			recv_gap <= recv_idle ? $urandom_range(0, 9) : 0;
			res.ready <= !recv_idle;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// Prediction on each accepted sample word and checking of each payoff word.
	always @(posedge clk) begin
		aop_pkg::res_t want;
		if (arst_n && samp.valid && samp.ready)
			if (path_advance(samp.normal_sample, want))
				payoff_q.push_back(want);
		if (arst_n && res.valid && res.ready) begin
			if (payoff_q.size() == 0) begin
				$error("payoff word with none expected");
				errors++;
			end else begin
				want = payoff_q.pop_front();
				if (res.path_payoff !== want.path_payoff) begin
					$error("path_payoff: expected %0h, got %0h", want.path_payoff,
						res.path_payoff);
					errors++;
				end
				if (res.payoff_accum !== want.payoff_accum) begin
					$error("payoff_accum: expected %0h, got %0h", want.payoff_accum,
						res.payoff_accum);
					errors++;
				end
				if (res.paths_done !== want.paths_done) begin
					$error("paths_done: expected %0h, got %0h", want.paths_done,
						res.paths_done);
					errors++;
				end
				if (res.empty_average !== want.empty_average) begin
					$error("empty_average: expected %0h, got %0h", want.empty_average,
						res.empty_average);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int sent, n;
		bit wide;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		samp.valid = 1'b0;
		samp.normal_sample = '0;
		res.ready = 1'b0;
		hold_start = 1'b0;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		errors = 0;
		cycles = 0;
		sh_spot = aop_pkg::SPOT_RESET;
		sh_strike = aop_pkg::SPOT_RESET;
		sh_drift = '0;
		sh_vol = '0;
		sh_steps = aop_pkg::STEPS_RESET;
		sh_avg_start = '0;
		sh_floating = 1'b0;
		sh_put = 1'b0;
		path_price = aop_pkg::SPOT_RESET;
		path_sum = 0;
		step_idx = 0;
		avg_cnt = 0;
		payoff_acc = 0;
		path_cnt = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Extreme samples with the largest volatility, every step averaged.
		cfg_write(aop_pkg::REG_STEPS, 1);
		cfg_write(aop_pkg::REG_AVG_START, 32'h1FFF);
		cfg_write(aop_pkg::REG_VOL, 32'h7F_FFFF);
		sample_q = '{16'sh7FFF, -16'sh8000, 16'sh0000};
		settle();
		// Most negative drift and volatility, floating strike put.
		cfg_write(aop_pkg::REG_VOL, 32'h80_0000);
		cfg_write(aop_pkg::REG_DRIFT, 32'h80_0000);
		cfg_write(aop_pkg::REG_FLOAT, 1);
		cfg_write(aop_pkg::REG_PUT, 1);
		sample_q = '{16'sh7FFF, -16'sh8000};
		settle();
		// Nothing averaged, and a zero step count acting as one.
		cfg_write(aop_pkg::REG_AVG_START, 4095);
		cfg_write(aop_pkg::REG_STEPS, 0);
		sample_q = '{16'sh0005, -16'sh0005};
		settle();
		// Largest spot, zero strike, largest drift.
		cfg_write(aop_pkg::REG_SPOT, 32'hFFFF_FFFF);
		cfg_write(aop_pkg::REG_STRIKE, 0);
		cfg_write(aop_pkg::REG_DRIFT, 32'h7F_FFFF);
		cfg_write(aop_pkg::REG_VOL, 0);
		cfg_write(aop_pkg::REG_AVG_START, 32'h1FFF);
		cfg_write(aop_pkg::REG_STEPS, 2);
		cfg_write(aop_pkg::REG_FLOAT, 0);
		cfg_write(aop_pkg::REG_PUT, 0);
		sample_q = '{16'sh0000, 16'sh0000, 16'sh0100, -16'sh0100};
		settle();
		// Zero spot, largest strike, put.
		cfg_write(aop_pkg::REG_SPOT, 0);
		cfg_write(aop_pkg::REG_STRIKE, 32'hFFFF_FFFF);
		cfg_write(aop_pkg::REG_PUT, 1);
		sample_q = '{16'sh1000, 16'sh2000};
		settle();
		// Step count lowered in the middle of a path.
		cfg_write(aop_pkg::REG_SPOT, 32'd6553600);
		cfg_write(aop_pkg::REG_DRIFT, 16);
		cfg_write(aop_pkg::REG_VOL, 20000);
		cfg_write(aop_pkg::REG_STEPS, 10);
		cfg_write(aop_pkg::REG_AVG_START, 2);
		sample_q = '{16'sh0400, -16'sh0400, 16'sh0800, 16'sh0123, -16'sh0321};
		settle();
		cfg_write(aop_pkg::REG_STEPS, 3);
		sample_q = '{16'sh0200};
		settle();

		// Receiver holds off while the sender keeps offering one-step paths.
		cfg_write(aop_pkg::REG_STEPS, 1);
		cfg_write(aop_pkg::REG_AVG_START, 32'h1FFF);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int i = 0; i < 40; i++)
			sample_q.push_back(rand_sample(0));
		settle();

		sent = 0;
		while (sent < 1000) begin
			wide = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 2) == 0)
				cfg_write(aop_pkg::REG_SPOT,
					wide ? $urandom() : $urandom_range(1 << 16, 300 << 16));
			if ($urandom_range(0, 2) == 0)
				cfg_write(aop_pkg::REG_STRIKE,
					wide ? $urandom() : $urandom_range(1 << 16, 300 << 16));
			if ($urandom_range(0, 2) == 0)
				cfg_write(aop_pkg::REG_DRIFT,
					wide ? $urandom() : $urandom_range(0, 4000) - 2000);
			if ($urandom_range(0, 2) == 0)
				cfg_write(aop_pkg::REG_VOL,
					wide ? $urandom() : $urandom_range(0, 60000) - 30000);
			if ($urandom_range(0, 1) == 0)
				cfg_write(aop_pkg::REG_STEPS,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
					: $urandom_range(1, 8));
			if ($urandom_range(0, 2) == 0)
				cfg_write(aop_pkg::REG_AVG_START,
					$urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 5) - 1);
			if ($urandom_range(0, 2) == 0)
				cfg_write(aop_pkg::REG_FLOAT, $urandom());
			if ($urandom_range(0, 2) == 0)
				cfg_write(aop_pkg::REG_PUT, $urandom());
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			n = $urandom_range(5, 60);
			for (int i = 0; i < n; i++)
				sample_q.push_back(rand_sample(wide));
			sent += n;
			settle();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/aop_pkg.sv
hw/rtl/aop_sample_if.sv
hw/rtl/aop_result_if.sv
hw/rtl/aop_ctrl.sv
hw/rtl/aop_dpath.sv
hw/rtl/asian_option_mc_path.sv
dv/asian_option_mc_path_tb.sv
